[design/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication or plain property, checked outside reset
`define ASSERT_PROP(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed: property does not hold");

// antecedent this cycle, consequent in the next one
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle property does not hold");

`endif

[design/qps_pkg.sv]
package qps_pkg;

	// position counter width, 8 to 64
	localparam int COUNT_WIDTH = 32;

	localparam int POS_WIDTH    = 32;
	localparam int TARGET_WIDTH = 32;
	localparam int DUTY_WIDTH   = 16;
	localparam int TOL_WIDTH    = 16;
	localparam int DATA_WIDTH   = 32;
	localparam int ADDR_WIDTH   = 3;

	// signed difference wide enough for target minus any count
	localparam int DIFF_WIDTH = ((COUNT_WIDTH > TARGET_WIDTH) ? COUNT_WIDTH : TARGET_WIDTH) + 2;

	localparam logic [DUTY_WIDTH-1:0] DUTY_LIMIT_RESET = 16'd400;
	localparam logic [TOL_WIDTH-1:0]  TOLERANCE_RESET  = 16'd10;

	// register word index, taken from paddr[2]
	localparam logic REG_DUTY_LIMIT = 1'b0;
	localparam logic REG_TOLERANCE  = 1'b1;

	typedef struct packed {
		logic [DUTY_WIDTH-1:0] duty;
		logic                  clockwise;
		logic                  in_band;
	} drive_t;

endpackage

[design/qps_in_if.sv]
interface qps_in_if import qps_pkg::*;;
	logic                           valid;
	logic                           ready;
	logic                           enc_a;
	logic                           enc_b;
	logic signed [TARGET_WIDTH-1:0] target_position;
	logic                           control_enable;
	logic                           clear_count;

	modport source (
		output valid, enc_a, enc_b, target_position, control_enable, clear_count,
		input  ready
	);

	modport sink (
		input  valid, enc_a, enc_b, target_position, control_enable, clear_count,
		output ready
	);
endinterface

[design/qps_out_if.sv]
interface qps_out_if import qps_pkg::*;;
	logic                        valid;
	logic                        ready;
	logic signed [POS_WIDTH-1:0] position;
	logic [DUTY_WIDTH-1:0]       duty;
	logic                        clockwise;
	logic                        at_target;
	logic                        double_edge_error;

	modport source (
		output valid, position, duty, clockwise, at_target, double_edge_error,
		input  ready
	);

	modport sink (
		input  valid, position, duty, clockwise, at_target, double_edge_error,
		output ready
	);
endinterface

[design/qps_servo.sv]
module qps_servo import qps_pkg::*; (
	input  logic [COUNT_WIDTH-1:0]  count,
	input  logic [TARGET_WIDTH-1:0] target,
	input  logic [DUTY_WIDTH-1:0]   duty_limit,
	input  logic [TOL_WIDTH-1:0]    tolerance,
	output drive_t                  drive
);

	logic signed [DIFF_WIDTH-1:0] count_ext;
	logic signed [DIFF_WIDTH-1:0] target_ext;
	logic signed [DIFF_WIDTH-1:0] diff_up;
	logic signed [DIFF_WIDTH-1:0] diff_dn;
	logic                         diff_pos;
	logic [DIFF_WIDTH-1:0]        mag;
	logic                         mag_ge_16;
	logic                         mag_ge_17;
	logic [18:0]                  three_mag;
	logic [18:0]                  six_mag;
	logic                         dead;
	logic                         sat;

	// target is known non-negative here
	assign count_ext  = DIFF_WIDTH'($signed(count));
	assign target_ext = $signed(DIFF_WIDTH'(target));

	// both directions in parallel, pick by sign
	assign diff_up  = target_ext - count_ext;
	assign diff_dn  = count_ext - target_ext;
	assign diff_pos = !diff_up[DIFF_WIDTH-1];
	assign mag      = diff_pos ? diff_up : diff_dn;

	assign mag_ge_16 = |mag[DIFF_WIDTH-1:16];
	assign mag_ge_17 = |mag[DIFF_WIDTH-1:17];

	assign three_mag = {1'b0, mag[16:0], 1'b0} + {2'b00, mag[16:0]};
	assign six_mag   = {three_mag[17:0], 1'b0};

	// dead zone: 3*|diff| <= 2*tolerance
	assign dead = !mag_ge_17 && (three_mag <= {2'b00, tolerance, 1'b0});
	assign sat  = mag_ge_16 || (six_mag > {3'b000, duty_limit});

	always_comb begin
		drive.in_band = dead;
		if (dead) begin
			drive.duty      = '0;
			drive.clockwise = 1'b0;
		end else begin
			drive.clockwise = diff_pos;
			drive.duty      = sat ? duty_limit : six_mag[DUTY_WIDTH-1:0];
		end
	end

endmodule

[design/quadrature_position_servo_top.sv]
// channel  | dir | words                                         | handshake
// sample   | in  | enc_a enc_b target_position control_enable    | valid/ready
//          |     | clear_count                                   |
// result   | out | position duty clockwise at_target             | valid/ready
//          |     | double_edge_error                             |
// apb      | in  | duty_limit @0x0, tolerance @0x4               | psel/penable
//
// one word per cycle unless result stalls; path: stage-1 regs, result regs
// the count is updated when a sample is taken, the drive one stage later
// sample.ready drops only while the result register is full and not taken
// arst_n clears the count, encoder history, drive state and config to defaults
module quadrature_position_servo_top import qps_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	qps_in_if.sink                sample,
	qps_out_if.source             result,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [ADDR_WIDTH-1:0] paddr,
	input  logic [DATA_WIDTH-1:0] pwdata,
	output logic [DATA_WIDTH-1:0] prdata,
	output logic                  pready
);

	logic [DUTY_WIDTH-1:0]   duty_limit_q;
	logic [TOL_WIDTH-1:0]    tolerance_q;

	logic                    prev_a_q;
	logic                    prev_b_q;
	logic [COUNT_WIDTH-1:0]  count_q;
	logic [COUNT_WIDTH-1:0]  count_base;
	logic [COUNT_WIDTH-1:0]  count_next;
	logic                    edge_a;
	logic                    edge_b;

	logic                    valid_s1;
	logic [COUNT_WIDTH-1:0]  count_s1;
	logic [TARGET_WIDTH-1:0] target_s1;
	logic                    enable_s1;
	logic                    dbl_s1;

	logic                    out_valid_q;
	logic [POS_WIDTH-1:0]    position_q;
	logic                    dbl_q;
	drive_t                  drive_q;
	drive_t                  drive_calc;
	logic [DIFF_WIDTH-1:0]   count_ext;

	logic                    adv_out;
	logic                    adv_in;
	logic                    take;

	// config port
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duty_limit_q <= DUTY_LIMIT_RESET;
			tolerance_q  <= TOLERANCE_RESET;
		end else if (psel && penable && pwrite && pready) begin
			unique case (paddr[2])
				REG_DUTY_LIMIT: duty_limit_q <= pwdata[DUTY_WIDTH-1:0];
				REG_TOLERANCE:  tolerance_q  <= pwdata[TOL_WIDTH-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_DUTY_LIMIT: prdata = DATA_WIDTH'(duty_limit_q);
			REG_TOLERANCE:  prdata = DATA_WIDTH'(tolerance_q);
		endcase
	end

	// pipeline flow
	assign adv_out      = !out_valid_q || result.ready;
	assign adv_in       = !valid_s1 || adv_out;
	assign sample.ready = adv_in;
	assign take         = sample.valid && adv_in;

	// quadrature decode
	assign edge_a     = sample.enc_a != prev_a_q;
	assign edge_b     = sample.enc_b != prev_b_q;
	assign count_base = sample.clear_count ? '0 : count_q;

	always_comb begin
		priority if (edge_a && edge_b) begin
			count_next = count_base;
		end else if (edge_a) begin
			count_next = (sample.enc_a == sample.enc_b) ? count_base + COUNT_WIDTH'(1)
				: count_base - COUNT_WIDTH'(1);
		end else if (edge_b) begin
			count_next = (sample.enc_a == sample.enc_b) ? count_base - COUNT_WIDTH'(1)
				: count_base + COUNT_WIDTH'(1);
		end else begin
			count_next = count_base;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_a_q <= 1'b0;
			prev_b_q <= 1'b0;
			count_q  <= '0;
			valid_s1 <= 1'b0;
		end else if (adv_in) begin
			valid_s1 <= sample.valid;
			if (sample.valid) begin
				prev_a_q <= sample.enc_a;
				prev_b_q <= sample.enc_b;
				count_q  <= count_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			count_s1  <= count_next;
			target_s1 <= sample.target_position;
			enable_s1 <= sample.control_enable;
			dbl_s1    <= edge_a && edge_b;
		end
	end

	// servo stage
	qps_servo u_servo (
		.count      (count_s1),
		.target     (target_s1),
		.duty_limit (duty_limit_q),
		.tolerance  (tolerance_q),
		.drive      (drive_calc)
	);

	assign count_ext = DIFF_WIDTH'($signed(count_s1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			drive_q     <= '0;
		end else if (adv_out) begin
			out_valid_q <= valid_s1;
			// negative target leaves the drive as it is
			if (valid_s1 && enable_s1 && !target_s1[TARGET_WIDTH-1]) begin
				drive_q <= drive_calc;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_out && valid_s1) begin
			position_q <= count_ext[POS_WIDTH-1:0];
			dbl_q      <= dbl_s1;
		end
	end

	assign result.valid             = out_valid_q;
	assign result.position          = $signed(position_q);
	assign result.duty              = drive_q.duty;
	assign result.clockwise         = drive_q.clockwise;
	assign result.at_target         = drive_q.in_band;
	assign result.double_edge_error = dbl_q;

endmodule

[design/qps_checker.sv]
`include "assert_macros.svh"

module qps_checker import qps_pkg::*; (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic signed [POS_WIDTH-1:0] position,
	input logic [DUTY_WIDTH-1:0]       duty,
	input logic                        clockwise,
	input logic                        at_target
);

	// a stalled result word keeps its position
	`ASSERT_NEXT(a_stall_pos, clk, arst_n, out_valid && !out_ready, $stable(position))

	// a taken result always frees room for a new sample
	`ASSERT_PROP(a_ready_flow, clk, arst_n, !out_ready || in_ready)

	// inside the dead zone the drive is off
	`ASSERT_PROP(a_dead_zone, clk, arst_n, !(out_valid && at_target) || (duty == '0 && !clockwise))

	// nothing comes out right after reset
	`ASSERT_PROP(a_reset_empty, clk, arst_n, !$rose(arst_n) || !out_valid)

endmodule

bind quadrature_position_servo_top qps_checker u_qps_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (sample.ready),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.position  (result.position),
	.duty      (result.duty),
	.clockwise (result.clockwise),
	.at_target (result.at_target)
);
